### rtl/hsm_pkg.sv
// Shared types, constants and helper functions for the heading and speed motion block.
// No dependencies; imported by hsm_cordic and heading_speed_motion_fsm_top.
`default_nettype none
package hsm_pkg;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int IterW           = 5;
  localparam int CordW           = 36;
  localparam int AngW            = 18;

  localparam logic signed [15:0] ANG_PI      = 16'sd25736;
  localparam logic signed [17:0] ANG_TWO_PI  = 18'sd51472;
  localparam logic signed [15:0] ANG_HALF_PI = 16'sd12868;
  localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;

  localparam logic [2:0] CFG_TOP_SPEED     = 3'd0;
  localparam logic [2:0] CFG_SPEED_STEP    = 3'd1;
  localparam logic [2:0] CFG_TURN_THRESH   = 3'd2;
  localparam logic [2:0] CFG_TURN_STEP     = 3'd3;
  localparam logic [2:0] CFG_TIME_STEP     = 3'd4;
  localparam logic [2:0] CFG_START_X       = 3'd5;
  localparam logic [2:0] CFG_START_Y       = 3'd6;
  localparam logic [2:0] CFG_START_HEADING = 3'd7;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'd0,
    MODE_TURNING = 3'd1,
    MODE_ACCEL   = 3'd2,
    MODE_DECEL   = 3'd3,
    MODE_MOVING  = 3'd4
  } motion_mode_t;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic               restart;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic [30:0]        speed;
    logic [2:0]         motion_mode;
  } out_beat_t;

  // Command to the shared CORDIC unit.
  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_cmd_t;

  // atan(2^-i) in Q3.13, rounded to nearest.
  function automatic logic [12:0] atan_q13(input logic [IterW-1:0] i);
    logic [12:0] v;
    case (i)
      5'd0:    v = 13'd6434;
      5'd1:    v = 13'd3798;
      5'd2:    v = 13'd2007;
      5'd3:    v = 13'd1019;
      5'd4:    v = 13'd511;
      5'd5:    v = 13'd256;
      5'd6:    v = 13'd128;
      5'd7:    v = 13'd64;
      5'd8:    v = 13'd32;
      5'd9:    v = 13'd16;
      5'd10:   v = 13'd8;
      5'd11:   v = 13'd4;
      5'd12:   v = 13'd2;
      5'd13:   v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // Brings an angle into [-pi, pi]; two corrections cover every input range used here.
  function automatic logic signed [15:0] wrap_ang(input logic signed [18:0] a);
    logic signed [18:0] v;
    v = a;
    for (int k = 0; k < 2; k++) begin
      if (v > 19'(ANG_PI)) v = v - 19'(ANG_TWO_PI);
      else if (v < -19'(ANG_PI)) v = v + 19'(ANG_TWO_PI);
    end
    return v[15:0];
  endfunction

endpackage
`default_nettype wire

### rtl/hsm_cordic.sv
// Shared iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on hsm_pkg.
`default_nettype none
module hsm_cordic #(
  parameter int CORDIC_ITERATIONS = hsm_pkg::CORDIC_ITER_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire hsm_pkg::cordic_cmd_t             cmd,
  input  wire logic signed [hsm_pkg::CordW-1:0] x_in,
  input  wire logic signed [hsm_pkg::CordW-1:0] y_in,
  input  wire logic signed [hsm_pkg::AngW-1:0]  z_in,
  output logic                                  done,
  output logic signed [hsm_pkg::CordW-1:0]      x_out,
  output logic signed [hsm_pkg::CordW-1:0]      y_out,
  output logic signed [hsm_pkg::AngW-1:0]       z_out
);
  import hsm_pkg::*;

  localparam logic [IterW-1:0] LastIter = IterW'(CORDIC_ITERATIONS - 1);

  logic signed [CordW-1:0] x_r, y_r;
  logic signed [AngW-1:0]  z_r;
  logic [IterW-1:0]        i_r;
  logic                    busy_r, vec_r, done_r;
  logic                    ccw;
  logic signed [CordW-1:0] xs, ys;
  logic signed [AngW-1:0]  at;

  // Vectoring drives y towards zero, rotation drives z towards zero.
  assign ccw = vec_r ? (y_r < 0) : (z_r >= 0);
  assign xs  = x_r >>> i_r;
  assign ys  = y_r >>> i_r;
  assign at  = AngW'($signed({1'b0, atan_q13(i_r)}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
      vec_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        vec_r  <= cmd.vectoring;
        i_r    <= '0;
        x_r    <= x_in;
        y_r    <= y_in;
        z_r    <= z_in;
      end else if (busy_r) begin
        if (ccw) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        i_r <= i_r + 1'b1;
        if (i_r == LastIter) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
endmodule
`default_nettype wire

### rtl/heading_speed_motion_fsm_top.sv
// Heading and speed motion machine: one result beat per input beat, one beat in flight.
// An ordinary tick runs S_VEC and S_WAITV (the shared CORDIC unit, vectoring), S_ANG, S_MODE,
// S_ROT and S_WAITR (the CORDIC unit again, rotation), then S_MD, S_MX, S_MY and S_POSY on the
// shared multiplier, used three times, and S_DONE; the next beat is accepted back in S_IDLE.
// A restart beat goes straight to S_DONE and frees the input when its result is registered.
// Synchronous active-low reset restores default registers, zero pose and speed, stopped mode.
`default_nettype none
module heading_speed_motion_fsm_top #(
  parameter int CORDIC_ITERATIONS = hsm_pkg::CORDIC_ITER_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire hsm_pkg::in_beat_t   in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output hsm_pkg::out_beat_t       out_data,
  input  wire                      cfg_we,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [31:0]         cfg_wdata
);
  import hsm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_VEC, S_WAITV, S_ANG, S_MODE, S_ROT, S_WAITR,
    S_MD, S_MX, S_MY, S_POSY, S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [30:0]        top_speed_r;
  logic [23:0]        speed_step_r;
  logic [14:0]        turn_thresh_r;
  logic [14:0]        turn_step_r;
  logic [23:0]        time_step_r;
  logic signed [31:0] start_x_r, start_y_r;
  logic signed [15:0] start_heading_r;

  // Vehicle state.
  logic signed [31:0] pos_x_r, pos_y_r;
  logic signed [15:0] heading_r;
  logic [30:0]        speed_r;
  motion_mode_t       mode_r;

  // Working registers for one tick.
  logic signed [31:0] goal_x_r, goal_y_r;
  logic               zero_r, neg_r;
  logic signed [15:0] need_r, delta_r;
  logic signed [21:0] cos_r, sin_r;
  logic [38:0]        dist_r;
  logic signed [64:0] prod_r;
  logic               out_valid_r;
  out_beat_t          out_r;

  // Shared CORDIC connections.
  cordic_cmd_t             cmd;
  logic signed [CordW-1:0] cx_in, cy_in, cx_out, cy_out;
  logic signed [AngW-1:0]  cz_in, cz_out;
  logic                    c_done;

  hsm_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .x_in  (cx_in),
    .y_in  (cy_in),
    .z_in  (cz_in),
    .done  (c_done),
    .x_out (cx_out),
    .y_out (cy_out),
    .z_out (cz_out)
  );

  // Bearing set-up: the vector from the vehicle to the goal, mirrored into the right
  // half-plane when it points left, with the angle starting at plus or minus pi.
  logic signed [32:0]       dx, dy;
  logic signed [CordW-1:0]  vx, vy;
  logic signed [AngW-1:0]   vz;
  assign dx = 33'(goal_x_r) - 33'(pos_x_r);
  assign dy = 33'(goal_y_r) - 33'(pos_y_r);

  always_comb begin
    vx = CordW'(dx);
    vy = CordW'(dy);
    vz = '0;
    if (dx < 0) begin
      vx = -CordW'(dx);
      vy = -CordW'(dy);
      vz = (dy >= 0) ? AngW'(ANG_PI) : -AngW'(ANG_PI);
    end
  end

  // Sine and cosine set-up: heading wrapped, then folded into [-pi/2, pi/2].
  logic signed [15:0] hw, hz;
  logic               hneg;
  always_comb begin
    hw   = wrap_ang(19'(heading_r));
    hz   = hw;
    hneg = 1'b0;
    if (hw > ANG_HALF_PI) begin
      hz   = hw - ANG_PI;
      hneg = 1'b1;
    end else if (hw < -ANG_HALF_PI) begin
      hz   = hw + ANG_PI;
      hneg = 1'b1;
    end
  end

  always_comb begin
    cmd.start     = (state_r == S_VEC) || (state_r == S_ROT);
    cmd.vectoring = (state_r == S_VEC);
    cx_in = (state_r == S_VEC) ? vx : CORDIC_GAIN;
    cy_in = (state_r == S_VEC) ? vy : '0;
    cz_in = (state_r == S_VEC) ? vz : AngW'(hz);
  end

  // Needed heading: the bearing wrapped, or zero when the vehicle is on the goal.
  logic signed [15:0] need_c;
  assign need_c = zero_r ? 16'sd0 : wrap_ang(19'(cz_out));

  // Mode machine inputs.
  logic [15:0]        mag;
  logic               off;
  logic [15:0]        turn;
  logic signed [15:0] turned;
  logic [31:0]        acc_sum;
  assign mag     = delta_r[15] ? 16'(-delta_r) : 16'(delta_r);
  assign off     = mag > 16'(turn_thresh_r);
  assign turn    = (mag < 16'(turn_step_r)) ? mag : 16'(turn_step_r);
  assign turned  = wrap_ang((delta_r > 0) ? 19'(heading_r) + 19'(turn)
                                          : 19'(heading_r) - 19'(turn));
  assign acc_sum = 32'(speed_r) + 32'(speed_step_r);

  // Cosine and sine in Q.30 after undoing the fold.
  logic signed [CordW-1:0] cxn, cyn;
  assign cxn = neg_r ? -cx_out : cx_out;
  assign cyn = neg_r ? -cy_out : cy_out;

  // One shared multiplier: speed times time step, then distance times cosine and sine.
  logic signed [39:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [64:0] mul_p;
  logic [38:0]        dist_c;
  assign dist_c = prod_r[54:16];
  assign mul_p  = mul_a * mul_b;
  always_comb begin
    mul_a = $signed({9'd0, speed_r});
    mul_b = $signed({1'b0, time_step_r});
    case (state_r)
      S_MX: begin
        mul_a = $signed({1'b0, dist_c});
        mul_b = 25'(cos_r);
      end
      S_MY: begin
        mul_a = $signed({1'b0, dist_r});
        mul_b = 25'(sin_r);
      end
      default: ;
    endcase
  end

  // Position step with saturation to the signed 32-bit range.
  logic signed [48:0] step;
  logic signed [49:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [31:0] pos_base;
  assign step     = 49'(prod_r >>> 16);
  assign pos_base = (state_r == S_MY) ? pos_x_r : pos_y_r;
  assign pos_sum  = 50'(pos_base) + 50'(step);
  always_comb begin
    if (pos_sum > 50'sd2147483647)       pos_sat = 32'sh7FFFFFFF;
    else if (pos_sum < -50'sd2147483648) pos_sat = 32'sh80000000;
    else                                 pos_sat = pos_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      top_speed_r     <= 31'd655360;
      speed_step_r    <= 24'd65536;
      turn_thresh_r   <= 15'd819;
      turn_step_r     <= 15'd819;
      time_step_r     <= 24'd6554;
      start_x_r       <= '0;
      start_y_r       <= '0;
      start_heading_r <= '0;
      pos_x_r         <= '0;
      pos_y_r         <= '0;
      heading_r       <= '0;
      speed_r         <= '0;
      mode_r          <= MODE_STOPPED;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TOP_SPEED:     top_speed_r     <= cfg_wdata[30:0];
          CFG_SPEED_STEP:    speed_step_r    <= cfg_wdata[23:0];
          CFG_TURN_THRESH:   turn_thresh_r   <= cfg_wdata[14:0];
          CFG_TURN_STEP:     turn_step_r     <= cfg_wdata[14:0];
          CFG_TIME_STEP:     time_step_r     <= cfg_wdata[23:0];
          CFG_START_X:       start_x_r       <= cfg_wdata;
          CFG_START_Y:       start_y_r       <= cfg_wdata;
          CFG_START_HEADING: start_heading_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      // A taken beat empties the output register unless a new result is loaded this cycle.
      if (out_valid_r && out_ready && (state_r != S_DONE)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.restart) begin
              pos_x_r   <= start_x_r;
              pos_y_r   <= start_y_r;
              heading_r <= start_heading_r;
              speed_r   <= '0;
              mode_r    <= MODE_STOPPED;
              state_r   <= S_DONE;
            end else begin
              goal_x_r <= in_data.goal_x;
              goal_y_r <= in_data.goal_y;
              state_r  <= S_VEC;
            end
          end
        end
        S_VEC: begin
          zero_r  <= (dx == 0) && (dy == 0);
          state_r <= S_WAITV;
        end
        S_WAITV: begin
          if (c_done) state_r <= S_ANG;
        end
        S_ANG: begin
          need_r  <= need_c;
          delta_r <= wrap_ang(19'(need_c) - 19'(heading_r));
          state_r <= S_MODE;
        end
        S_MODE: begin
          case (mode_r)
            MODE_TURNING: begin
              if (!off) begin
                mode_r    <= MODE_ACCEL;
                heading_r <= need_r;
                speed_r   <= '0;
              end else begin
                heading_r <= turned;
              end
            end
            MODE_ACCEL: begin
              if (off) begin
                mode_r <= MODE_DECEL;
              end else if (acc_sum >= 32'(top_speed_r)) begin
                mode_r  <= MODE_MOVING;
                speed_r <= top_speed_r;
              end else begin
                speed_r <= acc_sum[30:0];
              end
            end
            MODE_DECEL: begin
              if (speed_r <= 31'(speed_step_r)) begin
                speed_r <= '0;
                mode_r  <= off ? MODE_TURNING : MODE_ACCEL;
              end else begin
                speed_r <= speed_r - 31'(speed_step_r);
              end
            end
            MODE_MOVING: begin
              if (off) mode_r <= MODE_DECEL;
            end
            default: begin
              if (off) begin
                mode_r <= MODE_TURNING;
              end else begin
                mode_r    <= MODE_ACCEL;
                heading_r <= need_r;
                speed_r   <= '0;
              end
            end
          endcase
          state_r <= S_ROT;
        end
        S_ROT: begin
          neg_r   <= hneg;
          state_r <= S_WAITR;
        end
        S_WAITR: begin
          if (c_done) begin
            cos_r   <= 22'(cxn >>> 14);
            sin_r   <= 22'(cyn >>> 14);
            state_r <= S_MD;
          end
        end
        S_MD: begin
          prod_r  <= mul_p;
          state_r <= S_MX;
        end
        S_MX: begin
          dist_r  <= dist_c;
          prod_r  <= mul_p;
          state_r <= S_MY;
        end
        S_MY: begin
          pos_x_r <= pos_sat;
          prod_r  <= mul_p;
          state_r <= S_POSY;
        end
        S_POSY: begin
          pos_y_r <= pos_sat;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // The result beat leaves once the output register is free.
          if (!out_valid_r || out_ready) begin
            out_r.pos_x       <= pos_x_r;
            out_r.pos_y       <= pos_y_r;
            out_r.heading     <= heading_r;
            out_r.speed       <= speed_r;
            out_r.motion_mode <= mode_r;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire
